### hdl/sbq_pkg.sv
// ============================================================================
// sbq_pkg
// Shared types and constants for the stereo biquad filter.
// ============================================================================
package sbq_pkg;

    // Sample and coefficient word widths
    localparam int SMP_W  = 32;
    localparam int COEF_W = 32;
    localparam int PROD_W = SMP_W + COEF_W;
    // Five products summed: three guard bits
    localparam int ACC_W  = PROD_W + 3;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB2 = 3'd4;

    // Front queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
    } t_coefs;

    // Item as handed from the front queue to the back end
    typedef struct packed {
        logic                    ch;
        logic                    in_range;
        logic signed [SMP_W-1:0] smp;
    } t_item;

endpackage

### hdl/sbq_in_if.sv
// ============================================================================
// sbq_in_if
// Input sample channel: valid/ready handshake with channel and sample.
// ============================================================================
interface sbq_in_if;
    logic                             valid;
    logic                             ready;
    logic                             channel;
    logic signed [sbq_pkg::SMP_W-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

### hdl/sbq_out_if.sv
// ============================================================================
// sbq_out_if
// Output sample channel: valid/ready handshake with channel and sample.
// ============================================================================
interface sbq_out_if;
    logic                             valid;
    logic                             ready;
    logic                             out_channel;
    logic signed [sbq_pkg::SMP_W-1:0] sample_out;

    modport source (output valid, output out_channel, output sample_out, input ready);
    modport sink   (input valid, input out_channel, input sample_out, output ready);
endinterface

### hdl/sbq_coef.sv
// ============================================================================
// sbq_coef
// Coefficient register file, written through the configuration port.
// ============================================================================
module sbq_coef (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbq_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    output sbq_pkg::t_coefs                  o_coefs
);

    sbq_pkg::t_coefs r_coefs;

    // Decode the register index; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbq_pkg::REG_B0:  r_coefs.b0  <= i_cfg_wdata;
                sbq_pkg::REG_B1:  r_coefs.b1  <= i_cfg_wdata;
                sbq_pkg::REG_B2:  r_coefs.b2  <= i_cfg_wdata;
                sbq_pkg::REG_FB1: r_coefs.fb1 <= i_cfg_wdata;
                sbq_pkg::REG_FB2: r_coefs.fb2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

### hdl/sbq_front.sv
// ============================================================================
// sbq_front
// Input side: accept samples, tag out-of-range channels, and queue them.
// ============================================================================
module sbq_front #(
    parameter int CHANNELS = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sbq_in_if.sink          i_smp,
    output logic            o_valid,
    output sbq_pkg::t_item  o_item,
    input  logic            i_ready
);

    sbq_pkg::t_item                      r_q [sbq_pkg::Q_DEPTH];
    logic [sbq_pkg::Q_PTR_W-1:0]         r_wr_ptr;
    logic [sbq_pkg::Q_PTR_W-1:0]         r_rd_ptr;
    logic [sbq_pkg::Q_CNT_W-1:0]         r_count;
    logic                                push;
    logic                                pop;
    sbq_pkg::t_item                      in_item;

    // Classify the incoming transaction
    always_comb begin
        in_item.ch       = i_smp.channel;
        in_item.in_range = (CHANNELS > 1) || (i_smp.channel == 1'b0);
        in_item.smp      = i_smp.sample_in;
    end

    assign i_smp.ready = (r_count != sbq_pkg::Q_CNT_W'(sbq_pkg::Q_DEPTH));
    assign push        = i_smp.valid && i_smp.ready;
    assign o_valid     = (r_count != '0);
    assign pop         = o_valid && i_ready;
    assign o_item      = r_q[r_rd_ptr];

    // Hold queued payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            priority if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end

endmodule

### hdl/sbq_back.sv
// ============================================================================
// sbq_back
// Filter core: product stage, sum/saturate into the output register, and
// per-channel input and output history.
// ============================================================================
module sbq_back #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 16,
    parameter int CHANNELS    = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sbq_pkg::t_coefs i_coefs,
    input  logic            i_valid,
    input  sbq_pkg::t_item  i_item,
    output logic            o_ready,
    sbq_out_if.source       o_smp
);

    localparam int SMP_W  = sbq_pkg::SMP_W;
    localparam int PROD_W = sbq_pkg::PROD_W;
    localparam int ACC_W  = sbq_pkg::ACC_W;
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((67'sd1 <<< (SAMPLE_BITS - 1)) - 67'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // Per-channel history
    logic signed [SMP_W-1:0] r_in_d1  [CHANNELS];
    logic signed [SMP_W-1:0] r_in_d2  [CHANNELS];
    logic signed [SMP_W-1:0] r_out_d1 [CHANNELS];
    logic signed [SMP_W-1:0] r_out_d2 [CHANNELS];

    // Product stage
    logic                     r_m_valid;
    logic                     r_m_ch;
    logic                     r_m_inr;
    logic signed [SMP_W-1:0]  r_m_x;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4;

    // Output register
    logic                     r_o_valid;
    logic                     r_o_ch;
    logic signed [SMP_W-1:0]  r_o_smp;

    logic                     hazard;
    logic                     issue;
    logic                     m_adv;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  sat;
    logic signed [SMP_W-1:0]  n_o_smp;

    // Stall a new transaction whose channel history is still being written
    assign hazard  = r_m_valid && (r_m_ch == i_item.ch);
    assign m_adv   = r_m_valid && (!r_o_valid || o_smp.ready);
    assign o_ready = !hazard && (!r_m_valid || m_adv);
    assign issue   = i_valid && o_ready;
    assign rd_idx  = IDX_W'(i_item.ch);
    assign wr_idx  = IDX_W'(r_m_ch);

    // Multiply coefficients against the sample and the channel history
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_m_ch  <= i_item.ch;
            r_m_inr <= i_item.in_range;
            r_m_x   <= i_item.smp;
            r_p0    <= i_coefs.b0  * i_item.smp;
            r_p1    <= i_coefs.b1  * r_in_d1[rd_idx];
            r_p2    <= i_coefs.b2  * r_in_d2[rd_idx];
            r_p3    <= i_coefs.fb1 * r_out_d1[rd_idx];
            r_p4    <= i_coefs.fb2 * r_out_d2[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (issue) begin
            r_m_valid <= 1'b1;
        end else if (m_adv) begin
            r_m_valid <= 1'b0;
        end
    end

    // Scale each product down (floor), sum exactly, clamp, and zero out-of-range channels
    always_comb begin
        acc = ACC_W'(r_p0 >>> FRAC_BITS)
            + ACC_W'(r_p1 >>> FRAC_BITS)
            + ACC_W'(r_p2 >>> FRAC_BITS)
            + ACC_W'(r_p3 >>> FRAC_BITS)
            + ACC_W'(r_p4 >>> FRAC_BITS);
        priority if (acc > SAT_HI) begin
            sat = SAT_HI;
        end else if (acc < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = acc;
        end
        n_o_smp = r_m_inr ? sat[SMP_W-1:0] : '0;
    end

    // Shift the channel history as the result leaves the product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_in_d1[k]  <= '0;
                r_in_d2[k]  <= '0;
                r_out_d1[k] <= '0;
                r_out_d2[k] <= '0;
            end
        end else if (m_adv && r_m_inr) begin
            r_in_d2[wr_idx]  <= r_in_d1[wr_idx];
            r_in_d1[wr_idx]  <= r_m_x;
            r_out_d2[wr_idx] <= r_out_d1[wr_idx];
            r_out_d1[wr_idx] <= sat[SMP_W-1:0];
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (m_adv) begin
            r_o_ch  <= r_m_ch;
            r_o_smp <= n_o_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (m_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_smp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_smp.valid       = r_o_valid;
    assign o_smp.out_channel = r_o_ch;
    assign o_smp.sample_out  = r_o_smp;

endmodule

### hdl/stereo_biquad_filter.sv
// ============================================================================
// stereo_biquad_filter
// Two-channel direct form I biquad with software-written coefficients.
// ============================================================================
// Usage:
//   i_smp carries one transaction per sample: channel and a signed fixed-point
//   sample_in. o_smp returns one transaction per sample: out_channel and the
//   saturated sample_out. Both use valid/ready.
//   Coefficients are written through i_cfg_we / i_cfg_idx / i_cfg_wdata
//   (0 b0, 1 b1, 2 b2, 3 fb1, 4 fb2) while no sample is in flight.
// Path: o_smp.valid rises once the sample has passed the queue write at
//   the accepting edge, the product register and the output register.
// Throughput: one sample per cycle when consecutive samples alternate
//   channels and the receiver does not stall. When the same channel repeats,
//   the product stage waits for that channel's output history to be written.
// Reset: coefficients and all channel history clear to zero; the queue and
//   pipeline empty. No clearing pass is needed.
// Receiver stall: the output register holds its result, the product stage
//   and a two-entry input queue fill, then i_smp.ready drops.
// ============================================================================
module stereo_biquad_filter #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 16,
    parameter int CHANNELS    = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbq_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    sbq_in_if.sink                        i_smp,
    sbq_out_if.source                     o_smp
);

    sbq_pkg::t_coefs coefs;
    sbq_pkg::t_item  q_item;
    logic            q_valid;
    logic            q_ready;

    // Coefficient registers
    sbq_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coefs     (coefs)
    );

    // Accept and queue samples
    sbq_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    // Filter arithmetic and history
    sbq_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .CHANNELS    (CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coefs (coefs),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (q_ready),
        .o_smp   (o_smp)
    );

endmodule

### verif/tb_stereo_biquad_filter.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_stereo_biquad_filter
// Self-checking bench for the two-channel direct form I biquad. A predictor
// tracks coefficients and per-channel history, works out each filtered sample
// at input acceptance, and a checker compares every output transaction in
// order. Directed cases cover reset state, impulse response, saturation,
// rounding and unmapped register writes; random phases sweep coefficient
// sets under random idling and receiver stalls.
// ============================================================================
module tb_stereo_biquad_filter;

    localparam int SAMPLE_BITS      = 32;
    localparam int FRAC_BITS        = 16;
    localparam int CHANNELS         = 2;
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int BURST_MAX        = 18;
    localparam int NUM_REGS         = 5;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ITEMS      = 80;
    localparam int FLOOD_ITEMS      = 20;
    localparam int QUIET_ITEMS      = 50;

    localparam int SMP_W     = sbq_pkg::SMP_W;
    localparam int COEF_W    = sbq_pkg::COEF_W;
    localparam int CFG_IDX_W = sbq_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = sbq_pkg::CFG_DAT_W;

    localparam logic signed [SMP_W-1:0]  SMP_MAX    = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0]  SMP_MIN    = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_UNITY = COEF_W'(1) << FRAC_BITS;
    localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // Coefficient set kinds for the random phases
    typedef enum int {
        COEFS_STABLE,
        COEFS_WILD,
        COEFS_EXTREME
    } t_coef_kind;

    typedef struct packed {
        logic                    ch;
        logic signed [SMP_W-1:0] smp;
    } t_filt_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    sbq_in_if  smp_in_if();
    sbq_out_if smp_out_if();

    // Predictor state: coefficients and per-channel history
    sbq_pkg::t_coefs         model_coefs;
    logic signed [SMP_W-1:0] x_hist1 [CHANNELS];
    logic signed [SMP_W-1:0] x_hist2 [CHANNELS];
    logic signed [SMP_W-1:0] y_hist1 [CHANNELS];
    logic signed [SMP_W-1:0] y_hist2 [CHANNELS];

    t_filt_out expected_filtered_q[$];

    int err_count   = 0;
    int cycle_count = 0;
    bit bursts_off  = 1'b0;
    bit long_hold_req = 1'b0;
    int sink_stall_left = 0;

    stereo_biquad_filter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .CHANNELS    (CHANNELS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_smp       (smp_in_if),
        .o_smp       (smp_out_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_stereo_biquad_filter failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Full product, floored by the fraction width
    function automatic longint scaled_product(input logic signed [COEF_W-1:0] coef,
                                              input logic signed [SMP_W-1:0] smp);
        longint full;
        full = longint'(coef) * longint'(smp);
        return full >>> FRAC_BITS;
    endfunction

    // Filter one sample and advance that channel's history
    function automatic t_filt_out filter_sample(input logic ch,
                                                input logic signed [SMP_W-1:0] x);
        t_filt_out res;
        longint    acc;
        int        c;
        c      = int'(ch);
        res.ch = ch;
        // Out-of-range channel: zero result, history untouched
        if (c >= CHANNELS) begin
            res.smp = '0;
            return res;
        end
        acc = scaled_product(model_coefs.b0, x)
            + scaled_product(model_coefs.b1, x_hist1[c])
            + scaled_product(model_coefs.b2, x_hist2[c])
            + scaled_product(model_coefs.fb1, y_hist1[c])
            + scaled_product(model_coefs.fb2, y_hist2[c]);
        if (acc > SAT_HI) begin
            acc = SAT_HI;
        end else if (acc < SAT_LO) begin
            acc = SAT_LO;
        end
        x_hist2[c] = x_hist1[c];
        x_hist1[c] = x;
        y_hist2[c] = y_hist1[c];
        y_hist1[c] = acc[SMP_W-1:0];
        res.smp    = acc[SMP_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            sbq_pkg::REG_B0:  model_coefs.b0  = value;
            sbq_pkg::REG_B1:  model_coefs.b1  = value;
            sbq_pkg::REG_B2:  model_coefs.b2  = value;
            sbq_pkg::REG_FB1: model_coefs.fb1 = value;
            sbq_pkg::REG_FB2: model_coefs.fb2 = value;
            default: ; // unmapped index: drop the write
        endcase
    endtask

    task automatic set_coefs(input sbq_pkg::t_coefs c);
        write_reg(sbq_pkg::REG_B0, c.b0);
        write_reg(sbq_pkg::REG_B1, c.b1);
        write_reg(sbq_pkg::REG_B2, c.b2);
        write_reg(sbq_pkg::REG_FB1, c.fb1);
        write_reg(sbq_pkg::REG_FB2, c.fb2);
    endtask

    // Offer one sample, with an optional idle burst first; valid stays high
    task automatic send_sample(input logic ch, input logic signed [SMP_W-1:0] smp);
        @(negedge i_clk);
        if (!bursts_off && $urandom_range(0, 4) == 0) begin
            smp_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(negedge i_clk);
        end
        smp_in_if.valid     <= 1'b1;
        smp_in_if.channel   <= ch;
        smp_in_if.sample_in <= smp;
        do @(posedge i_clk); while (smp_in_if.ready !== 1'b1);
        expected_filtered_q.push_back(filter_sample(ch, smp));
    endtask

    // Drop valid and wait until every pending result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        smp_in_if.valid <= 1'b0;
        while (expected_filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver ready: random stall bursts, or one long hold on request
    initial begin : sink_ready_drive
        smp_out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                smp_out_if.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req   = 1'b0;
                sink_stall_left = LONG_HOLD_CYCLES - 1;
                smp_out_if.ready <= 1'b0;
            end else if (!bursts_off && $urandom_range(0, 7) == 0) begin
                sink_stall_left = $urandom_range(1, BURST_MAX) - 1;
                smp_out_if.ready <= 1'b0;
            end else begin
                smp_out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_filtered
        t_filt_out exp_res;
        if (i_rst_n === 1'b1 && smp_out_if.valid === 1'b1 && smp_out_if.ready === 1'b1) begin
            if (expected_filtered_q.size() == 0) begin
                report_mismatch($sformatf("output ch %0d sample %0d with nothing pending",
                                          smp_out_if.out_channel, smp_out_if.sample_out));
            end else begin
                exp_res = expected_filtered_q.pop_front();
                if (smp_out_if.out_channel !== exp_res.ch) begin
                    report_mismatch($sformatf("out_channel got %0d want %0d",
                                              smp_out_if.out_channel, exp_res.ch));
                end
                if (smp_out_if.sample_out !== exp_res.smp) begin
                    report_mismatch($sformatf("ch %0d sample_out got %0d want %0d",
                                              exp_res.ch, smp_out_if.sample_out, exp_res.smp));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic signed [COEF_W-1:0] coef_within(input int span);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3, 4: return SMP_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] extreme_coef();
        case ($urandom_range(0, 3))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            default: return COEF_UNITY;
        endcase
    endfunction

    function automatic sbq_pkg::t_coefs pick_coefs(input t_coef_kind kind);
        sbq_pkg::t_coefs c;
        case (kind)
            COEFS_STABLE: begin
                c.b0  = coef_within(COEF_UNITY);
                c.b1  = coef_within(COEF_UNITY);
                c.b2  = coef_within(COEF_UNITY);
                c.fb1 = coef_within(COEF_UNITY / 2);
                c.fb2 = coef_within(COEF_UNITY / 4);
            end
            COEFS_WILD: begin
                c = {$urandom, $urandom, $urandom, $urandom, $urandom};
            end
            default: begin
                c.b0  = extreme_coef();
                c.b1  = extreme_coef();
                c.b2  = extreme_coef();
                c.fb1 = extreme_coef();
                c.fb2 = extreme_coef();
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset coefficients are zero: every output is zero, history still fills
    task automatic test_reset_coefs();
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b1, SMP_MIN);
        send_sample(1'b0, -1);
        send_sample(1'b1, 1);
        wait_drained();
    endtask

    // Impulse on each channel, interleaved, to show the history per channel
    task automatic test_impulse_response();
        set_coefs('{b0: COEF_UNITY, b1: COEF_UNITY / 2, b2: -(COEF_UNITY / 4),
                    fb1: COEF_UNITY / 2, fb2: -(COEF_UNITY / 4)});
        for (int k = 0; k < 4; k++) begin
            send_sample(1'b0, (k == 0) ? COEF_UNITY : '0);
            send_sample(1'b1, (k == 0) ? -COEF_UNITY : '0);
        end
        wait_drained();
    endtask

    // Clamp at both ends, and floor rounding of negative products
    task automatic test_saturation_rounding();
        set_coefs('{b0: COEF_MAX, b1: COEF_MIN, b2: COEF_MAX, fb1: COEF_MAX, fb2: COEF_MIN});
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b1, SMP_MIN);
        send_sample(1'b0, SMP_MIN);
        send_sample(1'b1, SMP_MAX);
        wait_drained();
        set_coefs('{b0: COEF_MIN, b1: '0, b2: '0, fb1: '0, fb2: '0});
        send_sample(1'b0, SMP_MIN);
        send_sample(1'b1, SMP_MAX);
        wait_drained();
        set_coefs('{b0: COEF_UNITY / 2, b1: '0, b2: '0, fb1: '0, fb2: '0});
        send_sample(1'b0, -1);
        send_sample(1'b1, 1);
        send_sample(1'b0, -3);
        wait_drained();
    endtask

    // Writes above the last register must change nothing
    task automatic test_unmapped_index();
        for (int idx = NUM_REGS; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(CFG_IDX_W'(idx), $urandom);
        end
        send_sample(1'b0, 32'sh0003_0000);
        send_sample(1'b1, -32'sh0001_8000);
        wait_drained();
    endtask

    // Random phases, each with a fresh coefficient set
    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_coefs(pick_coefs(t_coef_kind'(p % 3)));
            bursts_off = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pause once mid-phase until all results are out
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_sample(1'($urandom), rand_sample());
            end
            wait_drained();
        end
        bursts_off = 1'b0;
    endtask

    // Hold the receiver off while the sender floods the input
    task automatic test_receiver_hold();
        set_coefs(pick_coefs(COEFS_STABLE));
        bursts_off    = 1'b1;
        long_hold_req = 1'b1;
        for (int n = 0; n < FLOOD_ITEMS; n++) begin
            send_sample(1'($urandom), rand_sample());
        end
        wait_drained();
        bursts_off = 1'b0;
    endtask

    // Closing stretch with no idling on either side
    task automatic test_full_rate();
        set_coefs(pick_coefs(COEFS_STABLE));
        bursts_off = 1'b1;
        for (int n = 0; n < QUIET_ITEMS; n++) begin
            send_sample(1'($urandom), rand_sample());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_wdata         = '0;
        smp_in_if.valid     = 1'b0;
        smp_in_if.channel   = 1'b0;
        smp_in_if.sample_in = '0;
        model_coefs         = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            x_hist1[c] = '0;
            x_hist2[c] = '0;
            y_hist1[c] = '0;
            y_hist2[c] = '0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_coefs();
        test_impulse_response();
        test_saturation_rounding();
        test_unmapped_index();
        test_random_phases();
        test_receiver_hold();
        test_full_rate();

        if (err_count == 0) begin
            $display("tb_stereo_biquad_filter passed");
        end else begin
            $display("tb_stereo_biquad_filter failed");
        end
        $finish;
    end

endmodule
